@@ hdl/fxalu_pkg.sv @@
// shared types and constants of the q24.8 fixed-point alu
`default_nettype none

package fxalu_pkg;

  localparam int WORD_W            = 32;
  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int OP_W              = 3;
  localparam int FLAG_W            = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MIN = 3'd4,
    OP_MAX = 3'd5
  } fxalu_op_t;

  // per-item control that rides alongside the divider stages
  typedef struct packed {
    fxalu_op_t         op;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              dz;
    logic              qneg;
    logic [WORD_W-1:0] alt;
  } fxalu_ctl_t;

endpackage

`default_nettype wire

@@ hdl/fxalu_div_stage.sv @@
// one registered restoring-division step producing a single quotient bit
`default_nettype none

module fxalu_div_stage #(
  parameter int DIV_W = fxalu_pkg::WORD_W + fxalu_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          load,
  input  wire                          vld_i,
  input  wire fxalu_pkg::fxalu_ctl_t   ctl_i,
  input  wire [fxalu_pkg::WORD_W-1:0]  rem_i,
  input  wire [DIV_W-1:0]              work_i,
  input  wire [fxalu_pkg::WORD_W-1:0]  dvs_i,
  output logic                         vld_o,
  output fxalu_pkg::fxalu_ctl_t        ctl_o,
  output logic [fxalu_pkg::WORD_W-1:0] rem_o,
  output logic [DIV_W-1:0]             work_o,
  output logic [fxalu_pkg::WORD_W-1:0] dvs_o
);

  localparam int W = fxalu_pkg::WORD_W;

  logic                  vld_r;
  fxalu_pkg::fxalu_ctl_t ctl_r;
  logic [W-1:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]      work_r, work_nxt;
  logic [W-1:0]          dvs_r;
  logic [W:0]            trial;
  logic [W:0]            diff;
  logic                  q_bit;

  always_comb begin
    trial    = {rem_i, work_i[DIV_W-1]};
    diff     = trial - {1'b0, dvs_i};
    // no borrow means the divisor fits
    q_bit    = ~diff[W];
    rem_nxt  = q_bit ? diff[W-1:0] : trial[W-1:0];
    work_nxt = {work_i[DIV_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r  <= ctl_i;
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
      dvs_r  <= dvs_i;
    end
  end

  assign vld_o  = vld_r;
  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign work_o = work_r;
  assign dvs_o  = dvs_r;

endmodule

`default_nettype wire

@@ hdl/fixed_point_q24_8_alu.sv @@
// Signed Q24.8 fixed-point ALU: add, subtract, multiply, divide, minimum, maximum
// with comparison flags. One item is accepted every clock cycle unless a stalled
// output has backed the pipeline up to the input. The divider resolves one
// quotient bit per pipeline stage over 32 + FRAC_BITS stages, after an operate
// stage (with a 32x32 multiplier) and a scaling stage, and before the output
// register. Every stage has its own valid bit and fills a bubble independently,
// so input transfers continue while a finished result waits for out_tready,
// until the bubbles are filled. Division by zero returns 0 with divide_by_zero
// set; unused action codes return 0.
`default_nettype none

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  wire  [2:0]  in_tuser,   // action [2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // result [31:0]
  output logic [3:0]  out_tuser   // a_greater [0], a_less [1], a_equal [2], divide_by_zero [3]
);

  localparam int W     = fxalu_pkg::WORD_W;
  localparam int DIV_W = W + FRAC_BITS;
  localparam int N_STG = DIV_W + 3;

  logic [N_STG-1:0] stg_vld;
  logic [N_STG-1:0] load;

  // a stage loads when it is empty or the stage after it loads
  genvar k;
  generate
    for (k = 0; k < N_STG - 1; k++) begin : g_load
      assign load[k] = ~stg_vld[k] | load[k+1];
    end
  endgenerate
  assign load[N_STG-1] = ~stg_vld[N_STG-1] | out_tready;
  assign in_tready     = load[0];

  // operate stage
  logic signed [W-1:0]   a_s, b_s;
  fxalu_pkg::fxalu_op_t  op_in;
  fxalu_pkg::fxalu_ctl_t op_ctl_nxt, op_ctl_r;
  logic signed [2*W-1:0] op_prod_nxt, op_prod_r;
  logic [W-1:0]          op_amag_nxt, op_amag_r;
  logic [W-1:0]          op_bmag_nxt, op_bmag_r;
  logic                  op_vld_r;

  always_comb begin
    a_s         = in_tdata[W-1:0];
    b_s         = in_tdata[2*W-1:W];
    op_in       = fxalu_pkg::fxalu_op_t'(in_tuser);
    op_ctl_nxt.op   = op_in;
    op_ctl_nxt.gt   = a_s > b_s;
    op_ctl_nxt.lt   = a_s < b_s;
    op_ctl_nxt.eq   = a_s == b_s;
    op_ctl_nxt.dz   = (op_in == fxalu_pkg::OP_DIV) && (b_s == '0);
    op_ctl_nxt.qneg = a_s[W-1] ^ b_s[W-1];
    unique case (op_in)
      fxalu_pkg::OP_ADD: op_ctl_nxt.alt = a_s + b_s;
      fxalu_pkg::OP_SUB: op_ctl_nxt.alt = a_s - b_s;
      fxalu_pkg::OP_MIN: op_ctl_nxt.alt = (a_s < b_s) ? a_s : b_s;
      fxalu_pkg::OP_MAX: op_ctl_nxt.alt = (a_s > b_s) ? a_s : b_s;
      default:           op_ctl_nxt.alt = '0;
    endcase
    op_prod_nxt = a_s * b_s;
    op_amag_nxt = a_s[W-1] ? (~a_s + 1'b1) : a_s;
    op_bmag_nxt = b_s[W-1] ? (~b_s + 1'b1) : b_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (load[0]) begin
      op_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      op_ctl_r  <= op_ctl_nxt;
      op_prod_r <= op_prod_nxt;
      op_amag_r <= op_amag_nxt;
      op_bmag_r <= op_bmag_nxt;
    end
  end

  // scaling stage: product shift; operand magnitudes pass through
  fxalu_pkg::fxalu_ctl_t sc_ctl_nxt, sc_ctl_r;
  logic [W-1:0]          sc_amag_r;
  logic [W-1:0]          sc_bmag_r;
  logic                  sc_vld_r;

  always_comb begin
    sc_ctl_nxt = op_ctl_r;
    if (op_ctl_r.op == fxalu_pkg::OP_MUL) begin
      sc_ctl_nxt.alt = op_prod_r[FRAC_BITS +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (load[1]) begin
      sc_vld_r <= op_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sc_ctl_r  <= sc_ctl_nxt;
      sc_amag_r <= op_amag_r;
      sc_bmag_r <= op_bmag_r;
    end
  end

  // divider stages, one quotient bit each
  logic                  dv_vld  [DIV_W+1];
  fxalu_pkg::fxalu_ctl_t dv_ctl  [DIV_W+1];
  logic [W-1:0]          dv_rem  [DIV_W+1];
  logic [DIV_W-1:0]      dv_work [DIV_W+1];
  logic [W-1:0]          dv_dvs  [DIV_W+1];

  assign dv_vld[0]  = sc_vld_r;
  assign dv_ctl[0]  = sc_ctl_r;
  assign dv_rem[0]  = '0;
  assign dv_work[0] = DIV_W'(sc_amag_r) << FRAC_BITS;
  assign dv_dvs[0]  = sc_bmag_r;

  genvar j;
  generate
    for (j = 0; j < DIV_W; j++) begin : g_div
      fxalu_div_stage #(
        .DIV_W (DIV_W)
      ) u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load[j+2]),
        .vld_i  (dv_vld[j]),
        .ctl_i  (dv_ctl[j]),
        .rem_i  (dv_rem[j]),
        .work_i (dv_work[j]),
        .dvs_i  (dv_dvs[j]),
        .vld_o  (dv_vld[j+1]),
        .ctl_o  (dv_ctl[j+1]),
        .rem_o  (dv_rem[j+1]),
        .work_o (dv_work[j+1]),
        .dvs_o  (dv_dvs[j+1])
      );
    end
  endgenerate

  // output register
  fxalu_pkg::fxalu_ctl_t         fin_ctl;
  logic [W-1:0]                  quo_mag;
  logic [W-1:0]                  quo;
  logic [W-1:0]                  res_nxt, res_r;
  logic [fxalu_pkg::FLAG_W-1:0]  flg_nxt, flg_r;
  logic                          out_vld_r;

  always_comb begin
    fin_ctl = dv_ctl[DIV_W];
    quo_mag = dv_work[DIV_W][W-1:0];
    quo     = fin_ctl.qneg ? (~quo_mag + 1'b1) : quo_mag;
    if (fin_ctl.op == fxalu_pkg::OP_DIV) begin
      res_nxt = fin_ctl.dz ? '0 : quo;
    end else begin
      res_nxt = fin_ctl.alt;
    end
    flg_nxt = {fin_ctl.dz, fin_ctl.eq, fin_ctl.lt, fin_ctl.gt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load[N_STG-1]) begin
      out_vld_r <= dv_vld[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (load[N_STG-1]) begin
      res_r <= res_nxt;
      flg_r <= flg_nxt;
    end
  end

  // collect stage valid bits for the load chain
  assign stg_vld[0] = op_vld_r;
  generate
    for (k = 1; k < N_STG - 1; k++) begin : g_vld
      assign stg_vld[k] = dv_vld[k-1];
    end
  endgenerate
  assign stg_vld[N_STG-1] = out_vld_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;
  assign out_tuser  = flg_r;

endmodule

`default_nettype wire

@@ hdl/fxalu_checker.sv @@
// port-level checks of the fixed-point alu and their binding to the top level
`default_nettype none

module fxalu_sva_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire [3:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // exactly one of greater, less, equal
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tuser[2:0]) == 1)
    else $error("comparison flags not exclusive");

  // division by zero gives zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tdata == 32'd0)
    else $error("non-zero result on division by zero");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented after reset");

endmodule

bind fixed_point_q24_8_alu fxalu_sva_checker u_fxalu_sva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
